// ===== hdl/ued_pkg.sv =====
// Shared types, character constants and hex helpers for the escape decoder.
// No dependencies.
package ued_pkg;

  localparam int unsigned HoldMax = 6;
  localparam int unsigned CntW    = 3;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowerU    = 8'h75;

  typedef logic [7:0]      byte_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef byte_t           win_t [HoldMax];

  typedef struct packed {
    byte_t value;
    logic  esc;
    cnt_t  used;
  } res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input byte_t c);
    logic [4:0] r;
    r = 5'b0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

// ===== hdl/ued_in_if.sv =====
// Input channel of the escape decoder: one raw byte and its end mark per item.
// Depends on ued_pkg.
interface ued_in_if;
  import ued_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

// ===== hdl/ued_out_if.sv =====
// Output channel of the escape decoder: one decoded byte and its flags per item.
// Depends on ued_pkg.
interface ued_out_if;
  import ued_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  was_escape;
  logic  last_out;

  modport source (output valid, output out_byte, output was_escape, output last_out,
                  input ready);
  modport sink   (input valid, input out_byte, input was_escape, input last_out,
                  output ready);
endinterface

// ===== hdl/ued_resolve.sv =====
// Resolves the head of the byte window: six-byte escape, bare five-byte escape,
// or a plain byte. Depends on ued_pkg.
module ued_resolve
  import ued_pkg::*;
(
  input  win_t win_i,
  input  cnt_t cnt_i,
  output res_t res_o
);

  logic [4:0] h1, h2, h3, h4, h5;
  logic       esc6, esc5;

  assign h1 = hex_val(win_i[1]);
  assign h2 = hex_val(win_i[2]);
  assign h3 = hex_val(win_i[3]);
  assign h4 = hex_val(win_i[4]);
  assign h5 = hex_val(win_i[5]);

  assign esc6 = (win_i[0] == ChBackslash || win_i[0] == ChSlash) &&
                (cnt_i >= cnt_t'(6)) && (win_i[1] == ChLowerU) &&
                h2[4] && h3[4] && h4[4] && h5[4];
  assign esc5 = (win_i[0] == ChLowerU) && (cnt_i >= cnt_t'(5)) &&
                h1[4] && h2[4] && h3[4] && h4[4];

  always_comb begin
    if (esc6) begin
      res_o = '{value: {h4[3:0], h5[3:0]}, esc: 1'b1, used: cnt_t'(6)};
    end else if (esc5) begin
      res_o = '{value: {h3[3:0], h4[3:0]}, esc: 1'b1, used: cnt_t'(5)};
    end else begin
      res_o = '{value: win_i[0], esc: 1'b0, used: cnt_t'(1)};
    end
  end

endmodule

// ===== hdl/unicode_escape_byte_decoder.sv =====
// Unicode escape byte decoder: "\uXXXX", "/uXXXX" and "uXXXX" become one byte.
// Throughput: one byte per cycle while a string streams and output is ready;
// a result appears in the output register in the cycle after the byte that
// completes a six-byte window. After the byte marked last, input stalls while
// the single shared head resolver flushes the window, a result per ready cycle.
// Reset empties the window and the output register; window bytes are not cleared.
module unicode_escape_byte_decoder
  import ued_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ued_in_if.sink    in_i,
  ued_out_if.source out_o
);

  win_t  buf_q, buf_d, win_new, src;
  cnt_t  cnt_q, cnt_d, src_cnt;
  logic  flush_q, flush_d;
  logic  out_valid_q, out_valid_d;
  byte_t out_byte_q, out_byte_d;
  logic  out_esc_q, out_esc_d, out_last_q, out_last_d;
  logic  out_load, accept, emit, done;
  res_t  res;

  assign out_load   = ~out_valid_q | out_o.ready;
  assign in_i.ready = ~flush_q & out_load;
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    win_new = buf_q;
    for (int i = 0; i < HoldMax; i++) begin
      if (cnt_q == cnt_t'(i)) begin
        win_new[i] = in_i.in_byte;
      end
    end
  end

  assign src     = flush_q ? buf_q : win_new;
  assign src_cnt = flush_q ? cnt_q : cnt_t'(HoldMax);

  ued_resolve u_resolve (
    .win_i (src),
    .cnt_i (src_cnt),
    .res_o (res)
  );

  assign done = res.used >= cnt_q;

  always_comb begin
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    flush_d     = flush_q;
    emit        = 1'b0;
    out_byte_d  = res.value;
    out_esc_d   = res.esc;
    out_last_d  = 1'b0;
    if (flush_q) begin
      if (out_load) begin
        emit       = 1'b1;
        out_last_d = done;
        if (done) begin
          flush_d = 1'b0;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q - res.used;
        end
      end
    end else if (accept) begin
      if (in_i.last_in) begin
        buf_d   = win_new;
        cnt_d   = cnt_q + cnt_t'(1);
        flush_d = 1'b1;
      end else if (cnt_q == cnt_t'(HoldMax - 1)) begin
        emit  = 1'b1;
        cnt_d = cnt_t'(HoldMax) - res.used;
      end else begin
        buf_d = win_new;
        cnt_d = cnt_q + cnt_t'(1);
      end
    end
    // advance the window past the resolved head
    if (emit) begin
      if (res.used == cnt_t'(1)) begin
        for (int i = 0; i < HoldMax - 1; i++) begin
          buf_d[i] = src[i+1];
        end
      end else if (res.used == cnt_t'(5)) begin
        buf_d[0] = src[HoldMax-1];
      end
    end
  end

  assign out_valid_d = out_load ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (out_load && emit) begin
      out_byte_q <= out_byte_d;
      out_esc_q  <= out_esc_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.was_escape = out_esc_q;
  assign out_o.last_out   = out_last_q;

endmodule
